/* hdl/brle8_pkg.sv */
package brle8_pkg;

   // input item operations
   localparam logic [1:0] OP_PALETTE = 2'd0;
   localparam logic [1:0] OP_DATA    = 2'd1;
   localparam logic [1:0] OP_START   = 2'd2;

   // result item kinds
   localparam logic [2:0] KIND_RUN    = 3'd0;
   localparam logic [2:0] KIND_END    = 3'd1;
   localparam logic [2:0] KIND_BADIDX = 3'd2;
   localparam logic [2:0] KIND_DELTA  = 3'd3;
   localparam logic [2:0] KIND_AFTER  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PCOUNT = 2'd2;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = 8;
   localparam int COLOR_W       = 24;

   typedef struct packed {
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [8:0]  palette_count;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [11:0] row;
      logic [11:0] column;
      logic [7:0]  run_length;
      logic        use_color;
   } evt_type;

endpackage

/* hdl/brle8_ram.sv */
module brle8_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/brle8_parser.sv */
module brle8_parser #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [1:0]                op,
   input  logic [7:0]                data_byte,
   input  brle8_pkg::cfg_type        cfg,
   output brle8_pkg::evt_type        evt,
   output logic                      rd_en,
   output logic [brle8_pkg::PAL_ADDR_W-1:0] rd_addr
);

   import brle8_pkg::*;

   localparam int WIDTH_LIMIT = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
   localparam int COL_W       = $clog2(WIDTH_LIMIT + 1);
   localparam int CMP_W       = (COL_W > 8) ? COL_W : 8;
   localparam logic [12:0] LIMIT13 = 13'(WIDTH_LIMIT);

   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_ESCAPE  = 3'd1;
   localparam logic [2:0] PH_COLOR   = 3'd2;
   localparam logic [2:0] PH_LITERAL = 3'd3;
   localparam logic [2:0] PH_PAD     = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       pend_ff, pend_in;
   logic [7:0]       lit_ff, lit_in;
   logic             pad_ff, pad_in;
   logic [11:0]      row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             fin_ff, fin_in;

   logic [12:0]      eff_w13, eff_h13, col13, h_minus;
   logic [COL_W-1:0] eff_w, room;
   logic [7:0]       run_len, clip, lit_dec;
   logic [CMP_W-1:0] col_sum;
   logic             bad_idx;

   // effective geometry and run clipping
   always_comb begin
      if (cfg.image_width == 13'd0) begin
         eff_w13 = 13'd1;
      end else if (cfg.image_width > LIMIT13) begin
         eff_w13 = LIMIT13;
      end else begin
         eff_w13 = cfg.image_width;
      end
      if (cfg.image_height == 13'd0) begin
         eff_h13 = 13'd1;
      end else if (cfg.image_height > 13'd4096) begin
         eff_h13 = 13'd4096;
      end else begin
         eff_h13 = cfg.image_height;
      end
      h_minus = eff_h13 - 13'd1;
      eff_w   = eff_w13[COL_W-1:0];
      room    = (col_ff < eff_w) ? (eff_w - col_ff) : '0;
      run_len = (phase_ff == PH_COLOR) ? pend_ff : 8'd1;
      if (CMP_W'(run_len) < CMP_W'(room)) begin
         clip = run_len;
      end else begin
         clip = 8'(room);
      end
      col_sum = CMP_W'(col_ff) + CMP_W'(clip);
      bad_idx = {1'b0, data_byte} >= cfg.palette_count;
      col13   = 13'(col_ff);
      lit_dec = (lit_ff != 8'd0) ? (lit_ff - 8'd1) : 8'd0;
   end

   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      lit_in   = lit_ff;
      pad_in   = pad_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      fin_in   = fin_ff;
      evt      = '0;
      evt.row    = row_ff;
      evt.column = col13[11:0];
      rd_en    = 1'b0;
      rd_addr  = data_byte;
      if (accept) begin
         unique case (op)
            OP_START: begin
               phase_in = PH_COUNT;
               pend_in  = '0;
               lit_in   = '0;
               pad_in   = 1'b0;
               row_in   = h_minus[11:0];
               col_in   = '0;
               fin_in   = 1'b0;
            end
            OP_DATA: begin
               if (fin_ff) begin
                  evt       = '0;
                  evt.valid = 1'b1;
                  evt.kind  = KIND_AFTER;
               end else begin
                  unique case (phase_ff) inside
                     PH_COUNT: begin
                        if (data_byte == 8'd0) begin
                           phase_in = PH_ESCAPE;
                        end else begin
                           pend_in  = data_byte;
                           phase_in = PH_COLOR;
                        end
                     end
                     PH_ESCAPE: begin
                        phase_in = PH_COUNT;
                        if (data_byte == 8'd0) begin
                           col_in = '0;
                           if (row_ff == 12'd0) begin
                              fin_in = 1'b1;
                           end else begin
                              row_in = row_ff - 12'd1;
                           end
                        end else if (data_byte == 8'd1) begin
                           evt.valid = 1'b1;
                           evt.kind  = KIND_END;
                           fin_in    = 1'b1;
                        end else if (data_byte == 8'd2) begin
                           evt.valid = 1'b1;
                           evt.kind  = KIND_DELTA;
                           fin_in    = 1'b1;
                        end else begin
                           lit_in   = data_byte;
                           pad_in   = data_byte[0];
                           phase_in = PH_LITERAL;
                        end
                     end
                     PH_COLOR, PH_LITERAL: begin
                        if (phase_ff == PH_COLOR) begin
                           phase_in = PH_COUNT;
                           pend_in  = '0;
                        end else begin
                           lit_in = lit_dec;
                           if (lit_dec == 8'd0) begin
                              phase_in = pad_ff ? PH_PAD : PH_COUNT;
                              pad_in   = 1'b0;
                           end
                        end
                        if (bad_idx) begin
                           evt.valid      = 1'b1;
                           evt.kind       = KIND_BADIDX;
                           evt.run_length = run_len;
                           fin_in         = 1'b1;
                        end else if (clip != 8'd0) begin
                           evt.valid      = 1'b1;
                           evt.kind       = KIND_RUN;
                           evt.run_length = clip;
                           evt.use_color  = 1'b1;
                           rd_en          = 1'b1;
                           col_in         = col_sum[COL_W-1:0];
                        end
                     end
                     default: begin
                        // pad byte: drop it
                        phase_in = PH_COUNT;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         pend_ff  <= '0;
         lit_ff   <= '0;
         pad_ff   <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         lit_ff   <= lit_in;
         pad_ff   <= pad_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

/* hdl/bmp_rle8_palette_decoder_top.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_op, req_palette_index, req_palette_color,
//                                           req_data_byte
// rsp       out        rsp_valid/rsp_ready  rsp_kind, rsp_row, rsp_column, rsp_run_length,
//                                           rsp_color
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// One item per cycle while rsp does not stall; a result passes the read stage, where the
// palette RAM is read, and then the output register before it shows on rsp.
// Reset is synchronous, clears parser state and sets the configuration to its defaults;
// palette contents stay undefined until written and need no clearing pass.
// A stalled rsp holds one result in the output register and one in the read stage;
// req stalls only when both are full.
module bmp_rle8_palette_decoder_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [11:0] rsp_row,
   output logic [11:0] rsp_column,
   output logic [7:0]  rsp_run_length,
   output logic [23:0] rsp_color,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   import brle8_pkg::*;

   cfg_type cfg_ff, cfg_in;
   evt_type evt;
   evt_type s1_evt_ff, s1_evt_in;
   logic    s1_valid_ff, s1_valid_in;
   logic    out_valid_ff, out_valid_in;
   evt_type out_evt_ff, out_evt_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;

   logic                  req_accept, s1_move, pal_wr;
   logic                  rd_en;
   logic [PAL_ADDR_W-1:0] rd_addr;
   logic [COLOR_W-1:0]    rd_data;

   // configuration: always ready; to be written only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  cfg_in.image_width   = csr_data;
            CSR_HEIGHT: cfg_in.image_height  = csr_data;
            CSR_PCOUNT: cfg_in.palette_count = csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   // advance the read stage when the output register is free or being drained
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;
   assign pal_wr     = req_accept && (req_op == OP_PALETTE);

   brle8_parser #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .op       (req_op),
      .data_byte(req_data_byte),
      .cfg      (cfg_ff),
      .evt      (evt),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr)
   );

   // palette store; a write and a read never come from the same item, and a read
   // in the cycle after a write sees the new entry
   brle8_ram #(
      .DATA_W(COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (pal_wr),
      .wr_addr(req_palette_index),
      .wr_data(req_palette_color),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_evt_in   = s1_evt_ff;
      if (req_accept && evt.valid) begin
         s1_valid_in = 1'b1;
         s1_evt_in   = evt;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_evt_in   = out_evt_ff;
      out_color_in = out_color_ff;
      if (s1_move) begin
         // merge the palette word into the result
         out_valid_in = 1'b1;
         out_evt_in   = s1_evt_ff;
         out_color_in = s1_evt_ff.use_color ? rd_data : '0;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= 13'd1;
         cfg_ff.image_height  <= 13'd1;
         cfg_ff.palette_count <= 9'd256;
         s1_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_evt_ff    <= s1_evt_in;
      out_evt_ff   <= out_evt_in;
      out_color_ff <= out_color_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_evt_ff.kind;
   assign rsp_row        = out_evt_ff.row;
   assign rsp_column     = out_evt_ff.column;
   assign rsp_run_length = out_evt_ff.run_length;
   assign rsp_color      = out_color_ff;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the RLE8 palette decoder. Items go in through req, results
// come back on rsp and are matched in order against a local decoder model.
module tb_top;
   import brle8_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 11;
   localparam int DUT_MAX_WIDTH = 4096;
   localparam int WIDTH_BOUND   = (DUT_MAX_WIDTH < 4096) ? DUT_MAX_WIDTH : 4096;
   localparam int HEIGHT_BOUND  = 4096;
   // slack after the last result so that items with no result leave the pipeline
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1320;
   localparam int RANDOM_PHASES = 6;
   localparam int HOLD_CYCLES   = 300;

   // op 3 has no meaning to the block; it must be dropped without a trace
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // escape codes that follow a zero count byte
   localparam logic [7:0] ESCAPE_MARK = 8'd0;
   localparam logic [7:0] ESC_EOL     = 8'd0;
   localparam logic [7:0] ESC_EOB     = 8'd1;
   localparam logic [7:0] ESC_DELTA   = 8'd2;

   typedef enum logic [2:0] {
      PARSE_COUNT, PARSE_ESCAPE, PARSE_COLOR, PARSE_LITERAL, PARSE_PAD
   } parse_state_type;

   typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN, RDY_SPARSE} ready_mode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] row;
      logic [11:0] column;
      logic [7:0]  run_length;
      logic [23:0] color;
   } run_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [7:0]  req_palette_index = '0;
   logic [23:0] req_palette_color = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [11:0] rsp_row;
   logic [11:0] rsp_column;
   logic [7:0]  rsp_run_length;
   logic [23:0] rsp_color;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   bmp_rle8_palette_decoder_top #(.MAX_WIDTH(DUT_MAX_WIDTH)) uut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder model: configuration copy, parser state and palette copy
   // ------------------------------------------------------------------
   cfg_type         cfg_mirror;
   parse_state_type parse_state;
   logic [7:0]      run_count;
   logic [7:0]      literals_remaining;
   logic            pad_due;
   logic [11:0]     row_pos;
   logic [12:0]     col_pos;
   logic            image_done;
   logic [23:0]     palette_mirror [PALETTE_DEPTH];
   run_report_type  pending_reports [$];

   int error_count = 0;
   int result_count = 0;
   int items_sent = 0;
   int cycle_count = 0;

   // sender burst control
   int burst_left = 0;
   int gap_max = 0;

   // receiver stall control; a test posts a long hold through hold_request
   int             hold_request = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   logic [6:0]     ready_pattern = 7'b1101001;

   function automatic void clear_decoder_state();
      cfg_mirror.image_width   = 13'd1;
      cfg_mirror.image_height  = 13'd1;
      cfg_mirror.palette_count = 9'd256;
      parse_state        = PARSE_COUNT;
      run_count          = '0;
      literals_remaining = '0;
      pad_due            = 1'b0;
      row_pos            = '0;
      col_pos            = '0;
      image_done         = 1'b0;
   endfunction

   function automatic int usable_width();
      int w;
      w = int'(cfg_mirror.image_width);
      if (w == 0) w = 1;
      if (w > WIDTH_BOUND) w = WIDTH_BOUND;
      return w;
   endfunction

   function automatic int usable_height();
      int h;
      h = int'(cfg_mirror.image_height);
      if (h == 0) h = 1;
      if (h > HEIGHT_BOUND) h = HEIGHT_BOUND;
      return h;
   endfunction

   function automatic void expect_report(logic [2:0] kind, logic [11:0] row,
                                         logic [11:0] column, logic [7:0] length,
                                         logic [23:0] color);
      pending_reports.push_back('{kind, row, column, length, color});
   endfunction

   // Place a run at the current position: clip to the row end, flag a bad index.
   function automatic void place_run(logic [7:0] index, logic [7:0] length);
      int room;
      int clipped;
      room = (int'(col_pos) < usable_width()) ? usable_width() - int'(col_pos) : 0;
      clipped = (int'(length) < room) ? int'(length) : room;
      if ({1'b0, index} >= cfg_mirror.palette_count) begin
         expect_report(KIND_BADIDX, row_pos, col_pos[11:0], length, '0);
         image_done = 1'b1;
      end else if (clipped != 0) begin
         expect_report(KIND_RUN, row_pos, col_pos[11:0], 8'(clipped),
                       palette_mirror[index]);
         col_pos = col_pos + 13'(clipped);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] code);
      if (image_done) begin
         expect_report(KIND_AFTER, '0, '0, '0, '0);
         return;
      end
      case (parse_state)
         PARSE_COUNT: begin
            if (code == ESCAPE_MARK) begin
               parse_state = PARSE_ESCAPE;
            end else begin
               run_count   = code;
               parse_state = PARSE_COLOR;
            end
         end
         PARSE_ESCAPE: begin
            parse_state = PARSE_COUNT;
            if (code == ESC_EOL) begin
               col_pos = '0;
               if (row_pos == 12'd0) image_done = 1'b1;
               else row_pos = row_pos - 12'd1;
            end else if (code == ESC_EOB) begin
               expect_report(KIND_END, row_pos, col_pos[11:0], '0, '0);
               image_done = 1'b1;
            end else if (code == ESC_DELTA) begin
               expect_report(KIND_DELTA, row_pos, col_pos[11:0], '0, '0);
               image_done = 1'b1;
            end else begin
               literals_remaining = code;
               pad_due            = code[0];
               parse_state        = PARSE_LITERAL;
            end
         end
         PARSE_COLOR: begin
            parse_state = PARSE_COUNT;
            place_run(code, run_count);
            run_count = '0;
         end
         PARSE_LITERAL: begin
            place_run(code, 8'd1);
            if (literals_remaining != 8'd0) literals_remaining = literals_remaining - 8'd1;
            if (literals_remaining == 8'd0) begin
               parse_state = pad_due ? PARSE_PAD : PARSE_COUNT;
               pad_due     = 1'b0;
            end
         end
         default: parse_state = PARSE_COUNT;
      endcase
   endfunction

   function automatic void decode_item(logic [1:0] op, logic [7:0] index,
                                       logic [23:0] color, logic [7:0] code);
      case (op)
         OP_PALETTE: palette_mirror[index] = color;
         OP_START: begin
            parse_state        = PARSE_COUNT;
            run_count          = '0;
            literals_remaining = '0;
            pad_due            = 1'b0;
            row_pos            = 12'(usable_height() - 1);
            col_pos            = '0;
            image_done         = 1'b0;
         end
         OP_DATA: decode_byte(code);
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one item. Between bursts drop valid for a random gap; otherwise keep
   // valid high and swap the payload at the accepting edge.
   task automatic send_item(logic [1:0] op, logic [7:0] index, logic [23:0] color,
                            logic [7:0] code);
      int gap;
      gap = 0;
      if (gap_max > 0) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, gap_max);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_palette_index <= index;
      req_palette_color <= color;
      req_data_byte     <= code;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_item(op, index, color, code);
      if (op != OP_IGNORED) items_sent++;
   endtask

   // The palette fields mean nothing for data bytes; randomize them anyway.
   task automatic send_data(logic [7:0] code);
      send_item(OP_DATA, 8'($urandom), 24'($urandom), code);
   endtask

   task automatic send_start();
      send_item(OP_START, 8'($urandom), 24'($urandom), 8'($urandom));
   endtask

   task automatic send_escape(logic [7:0] code);
      send_data(ESCAPE_MARK);
      send_data(code);
   endtask

   task automatic send_run(logic [7:0] count, logic [7:0] index);
      send_data(count);
      send_data(index);
   endtask

   // Mostly a valid palette index; now and then one at or past the palette count.
   function automatic logic [7:0] pick_index();
      int limit;
      limit = (int'(cfg_mirror.palette_count) > PALETTE_DEPTH) ? PALETTE_DEPTH
                                                              : int'(cfg_mirror.palette_count);
      if (limit == 0 || (limit < PALETTE_DEPTH && $urandom_range(0, 39) == 0))
         return 8'($urandom_range(limit, PALETTE_DEPTH - 1));
      return 8'($urandom_range(0, limit - 1));
   endfunction

   function automatic logic [7:0] pick_count();
      int r;
      int top;
      r = $urandom_range(0, 9);
      top = (usable_width() < 255) ? usable_width() : 255;
      if (r < 6) return 8'($urandom_range(1, 8));
      if (r < 9) return 8'($urandom_range(1, top));
      return 8'($urandom_range(200, 255));
   endfunction

   // Absolute block: escape with the count, the literals, and a pad byte if odd.
   task automatic send_literals(logic [7:0] n);
      send_escape(n);
      repeat (n) send_data(pick_index());
      if (n[0]) send_data(8'($urandom));
   endtask

   // Drop valid and hold until every expected result is back.
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   // Let items with no result leave the pipeline too.
   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [1:0] index, logic [12:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_WIDTH:  cfg_mirror.image_width   = data;
         CSR_HEIGHT: cfg_mirror.image_height  = data;
         CSR_PCOUNT: cfg_mirror.palette_count = data[8:0];
         default: ;
      endcase
   endtask

   // Only call while idle; valid stays high across the three writes.
   task automatic write_config(logic [12:0] width, logic [12:0] height,
                               logic [12:0] count_word);
      csr_put(CSR_WIDTH, width);
      csr_put(CSR_HEIGHT, height);
      csr_put(CSR_PCOUNT, count_word);
      csr_valid <= 1'b0;
   endtask

   // One image: mostly well-formed codes with random content, a little noise,
   // then an end marker or not, and sometimes trailing bytes.
   task automatic random_image();
      int n_codes;
      int choice;
      if ($urandom_range(0, 9) != 0) send_start();
      n_codes = $urandom_range(1, 14);
      repeat (n_codes) begin
         choice = $urandom_range(0, 99);
         if (choice < 45)
            send_run(pick_count(), pick_index());
         else if (choice < 65)
            send_literals(($urandom_range(0, 29) == 0) ? 8'($urandom_range(3, 255))
                                                       : 8'($urandom_range(3, 12)));
         else if (choice < 85)
            send_escape(ESC_EOL);
         else if (choice < 90)
            send_item(OP_PALETTE, 8'($urandom), 24'($urandom), 8'($urandom));
         else if (choice < 95)
            send_item(OP_IGNORED, 8'($urandom), 24'($urandom), 8'($urandom));
         else
            send_data(8'($urandom));
      end
      choice = $urandom_range(0, 9);
      if (choice < 7) send_escape(ESC_EOB);
      else if (choice == 7) send_escape(ESC_DELTA);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_data(8'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fill every palette entry so no later read can hit an unwritten one.
   task automatic test_palette_load();
      gap_max = 3;
      send_item(OP_PALETTE, 8'd0, 24'h000000, 8'($urandom));
      for (int i = 1; i < PALETTE_DEPTH - 1; i++)
         send_item(OP_PALETTE, 8'(i), 24'($urandom), 8'($urandom));
      send_item(OP_PALETTE, 8'hFF, 24'hFFFFFF, 8'($urandom));
   endtask

   // Reset config, no start: decode from row 0, end of line on the top row
   // finishes silently, and the next byte reports data after the end.
   task automatic test_before_start();
      send_run(8'd3, 8'd7);
      send_escape(ESC_EOL);
      send_data(8'd5);
   endtask

   // Width 3, heights and counts past their bounds: the longest run clips, a
   // literal block past the row end gives nothing, the column saturates.
   task automatic test_escapes_and_clipping();
      wait_idle();
      write_config(13'd3, 13'h1FFF, 13'h1FFF);
      send_start();
      send_run(8'd255, 8'd255);
      send_literals(8'd3);
      send_escape(ESC_EOB);
   endtask

   // Zero width, height and palette count: delta, bad run index and bad
   // literal index each finish the image.
   task automatic test_bad_codes();
      wait_idle();
      write_config(13'd0, 13'd0, 13'd0);
      send_start();
      send_escape(ESC_DELTA);
      send_start();
      send_run(8'd1, pick_index());
      send_start();
      send_literals(8'd3);
   endtask

   // Hold rsp off for a long stretch while req keeps offering runs with no gaps,
   // so the block fills and stalls its input.
   task automatic test_backpressure();
      wait_idle();
      write_config(13'd4096, 13'd64, 13'd256);
      gap_max = 0;
      send_start();
      hold_request = HOLD_CYCLES;
      repeat (40) send_run(8'd1, pick_index());
      send_escape(ESC_EOB);
   endtask

   // Pause the sender mid-image until all results are back, then carry on.
   task automatic test_pause();
      wait_idle();
      write_config(13'd200, 13'd8, 13'd256);
      gap_max = 4;
      send_start();
      repeat (4) begin
         repeat (6) send_run(pick_count(), pick_index());
         wait_results();
      end
      send_escape(ESC_EOB);
   endtask

   task automatic test_random_stream();
      int stop_at;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: write_config(13'($urandom_range(1, 40)), 13'($urandom_range(1, 8)), 13'd256);
            1: write_config(13'($urandom_range(1, 16)), 13'($urandom_range(1, 4)),
                            13'($urandom_range(1, 255)));
            2: write_config(13'h1FFF, 13'd4096, 13'h1FFF);
            3: write_config(13'($urandom_range(20, 300)), 13'($urandom_range(2, 30)),
                            13'($urandom));
            4: write_config(13'd4096, 13'd1, 13'd255);
            default: write_config(13'($urandom_range(0, 64)), 13'($urandom_range(0, 16)),
                                  13'd256);
         endcase
         gap_max = (phase % 3 == 0) ? 0 : 2 + phase;
         stop_at = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < stop_at) random_image();
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: long holds on request, else a stall pattern that changes
   // every so often
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_ready <= 1'b1;
            RDY_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
            RDY_PATTERN: begin
               ready_pattern = {ready_pattern[5:0], ready_pattern[6]};
               rsp_ready <= ready_pattern[0];
            end
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic report_error(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0h, expected %0h",
                                result_count, name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      run_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            report_error($sformatf("result %0d arrived with nothing expected",
                                   result_count));
         end else begin
            want = pending_reports.pop_front();
            check_field("kind", 24'(rsp_kind), 24'(want.kind));
            check_field("row", 24'(rsp_row), 24'(want.row));
            check_field("column", 24'(rsp_column), 24'(want.column));
            check_field("run_length", 24'(rsp_run_length), 24'(want.run_length));
            check_field("color", rsp_color, want.color);
         end
         result_count++;
      end
   end

   // Watchdog: end the run if the traffic hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_reports.size());
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      clear_decoder_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_palette_load();
      test_before_start();
      test_escapes_and_clipping();
      test_bad_codes();
      test_backpressure();
      test_pause();
      test_random_stream();
      // drain: all results back, then settle time for stray output
      wait_idle();
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
hdl/brle8_pkg.sv
hdl/brle8_ram.sv
hdl/brle8_parser.sv
hdl/bmp_rle8_palette_decoder_top.sv
verif/tb_top.sv
